@@ hw/rtl/linked_list_queue_manager_unit_defines.svh @@
// assertion macros shared by the linked list queue manager modules
`ifndef LINKED_LIST_QUEUE_MANAGER_UNIT_DEFINES_SVH
`define LINKED_LIST_QUEUE_MANAGER_UNIT_DEFINES_SVH

// expression must never hold while out of reset
`define LLQM_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("llqm assertion failed: never");

// consequent must hold in the same cycle as the antecedent
`define LLQM_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("llqm assertion failed: implies");

// consequent must hold in the cycle after the antecedent
`define LLQM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("llqm assertion failed: next");

`endif

@@ hw/rtl/llqm_pkg.sv @@
// shared types and constants for the linked list queue manager
`timescale 1ns / 1ps
`default_nettype none

package llqm_pkg;

   localparam int unsigned CMD_W         = 2;
   localparam int unsigned HANDLE_W      = 8;
   localparam int unsigned COUNT_W       = 9;
   localparam int unsigned MAX_POOL      = 256;
   localparam int unsigned NODES_DEFAULT = 256;

   typedef enum logic [CMD_W-1:0] {
      CMD_PUSH_BACK  = 2'd0,
      CMD_PUSH_FRONT = 2'd1,
      CMD_POP_FRONT  = 2'd2,
      CMD_QUERY      = 2'd3
   } cmd_type;

   // controller to datapath strobes
   typedef struct packed {
      logic capture;
      logic commit;
   } ctrl_cmd_type;

endpackage

`default_nettype wire

@@ hw/rtl/llqm_req_if.sv @@
// command channel interface
`timescale 1ns / 1ps
`default_nettype none

interface llqm_req_if;
   logic                            valid;
   logic                            ready;
   logic [llqm_pkg::CMD_W-1:0]      command;
   logic [llqm_pkg::HANDLE_W-1:0]   node_handle;

   modport source (output valid, output command, output node_handle, input ready);
   modport sink   (input valid, input command, input node_handle, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/llqm_rsp_if.sv @@
// result channel interface
`timescale 1ns / 1ps
`default_nettype none

interface llqm_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [llqm_pkg::HANDLE_W-1:0]   front_handle;
   logic                            is_empty;
   logic [llqm_pkg::COUNT_W-1:0]    entry_count;
   logic [llqm_pkg::HANDLE_W-1:0]   popped_handle;
   logic                            popped_valid;

   modport source (output valid, output front_handle, output is_empty, output entry_count,
                   output popped_handle, output popped_valid, input ready);
   modport sink   (input valid, input front_handle, input is_empty, input entry_count,
                   input popped_handle, input popped_valid, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/llqm_ctrl.sv @@
// controller state machine: accept, execute, hand result to output register
`timescale 1ns / 1ps
`default_nettype none

`include "linked_list_queue_manager_unit_defines.svh"

module llqm_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output      logic                   req_ready,
   output      logic                   rsp_valid,
   input  wire logic                   rsp_ready,
   output      llqm_pkg::ctrl_cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;

   assign req_ready   = (state_ff == ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign cmd.capture = req_valid && req_ready;
   // the output register must be free or draining before a new result lands
   assign cmd.commit  = (state_ff == ST_EXEC) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (cmd.capture) begin
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (cmd.commit) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
         if (cmd.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   `LLQM_ASSERT_NEVER(a_no_overlap, clock, reset, cmd.capture && cmd.commit)
   `LLQM_ASSERT_NEXT(a_capture_exec, clock, reset, cmd.capture, state_ff == ST_EXEC)
   `LLQM_ASSERT_NEXT(a_commit_shows, clock, reset, cmd.commit, rsp_valid_ff)

endmodule

`default_nettype wire

@@ hw/rtl/llqm_dp.sv @@
// datapath: head, tail, count, link memory and result register
`timescale 1ns / 1ps
`default_nettype none

`include "linked_list_queue_manager_unit_defines.svh"

module llqm_dp #(
   parameter int unsigned POOL = llqm_pkg::MAX_POOL
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire llqm_pkg::ctrl_cmd_type        cmd,
   input  wire logic [llqm_pkg::CMD_W-1:0]    command,
   input  wire logic [llqm_pkg::HANDLE_W-1:0] node_handle,
   output      logic [llqm_pkg::HANDLE_W-1:0] front_handle,
   output      logic                          is_empty,
   output      logic [llqm_pkg::COUNT_W-1:0]  entry_count,
   output      logic [llqm_pkg::HANDLE_W-1:0] popped_handle,
   output      logic                          popped_valid
);

   localparam int unsigned IDX_W  = (POOL > 1) ? $clog2(POOL) : 1;
   localparam int unsigned HW     = llqm_pkg::HANDLE_W;
   localparam int unsigned CW     = llqm_pkg::COUNT_W;
   localparam logic [CW-1:0] POOL_C = CW'(POOL);

   logic [HW-1:0]        link_mem [POOL];

   logic [HW-1:0]        head_ff, head_in;
   logic [HW-1:0]        tail_ff, tail_in;
   logic [CW-1:0]        count_ff, count_in;
   llqm_pkg::cmd_type    cmd_ff;
   logic [HW-1:0]        node_ff;
   logic [HW-1:0]        rdata_ff;

   logic [HW-1:0]        front_ff, popped_ff;
   logic                 empty_ff, popped_valid_ff;
   logic [CW-1:0]        entry_ff;

   logic                 can_push;
   logic                 mem_we;
   logic [IDX_W-1:0]     mem_waddr;
   logic [HW-1:0]        mem_wdata;
   logic [HW-1:0]        popped_in;
   logic                 popped_valid_in;

   assign can_push = ({1'b0, node_ff} < POOL_C) && (count_ff < POOL_C);

   always_comb begin
      head_in         = head_ff;
      tail_in         = tail_ff;
      count_in        = count_ff;
      mem_we          = 1'b0;
      mem_waddr       = tail_ff[IDX_W-1:0];
      mem_wdata       = node_ff;
      popped_in       = '0;
      popped_valid_in = 1'b0;
      case (cmd_ff)
         llqm_pkg::CMD_PUSH_BACK: begin
            if (can_push) begin
               if (count_ff != '0) begin
                  mem_we = 1'b1;
               end else begin
                  head_in = node_ff;
               end
               tail_in  = node_ff;
               count_in = count_ff + CW'(1);
            end
         end
         llqm_pkg::CMD_PUSH_FRONT: begin
            if (can_push) begin
               if (count_ff != '0) begin
                  mem_we    = 1'b1;
                  mem_waddr = node_ff[IDX_W-1:0];
                  mem_wdata = head_ff;
               end else begin
                  tail_in = node_ff;
               end
               head_in  = node_ff;
               count_in = count_ff + CW'(1);
            end
         end
         llqm_pkg::CMD_POP_FRONT: begin
            if (count_ff != '0) begin
               popped_in       = head_ff;
               popped_valid_in = 1'b1;
               count_in        = count_ff - CW'(1);
               // last node out leaves head and tail as they were
               if (count_in != '0) begin
                  head_in = rdata_ff;
               end
            end
         end
         llqm_pkg::CMD_QUERY: begin
         end
         default: begin
         end
      endcase
   end

   // successor of the head is fetched during the accept cycle
   always_ff @(posedge clock) begin
      if (cmd.commit && mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.capture) begin
         rdata_ff <= link_mem[head_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff  <= llqm_pkg::cmd_type'(command);
         node_ff <= node_handle;
      end
      if (cmd.commit) begin
         front_ff        <= (count_in != '0) ? head_in : '0;
         empty_ff        <= (count_in == '0);
         entry_ff        <= count_in;
         popped_ff       <= popped_in;
         popped_valid_ff <= popped_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.commit) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   assign front_handle  = front_ff;
   assign is_empty      = empty_ff;
   assign entry_count   = entry_ff;
   assign popped_handle = popped_ff;
   assign popped_valid  = popped_valid_ff;

   `LLQM_ASSERT_NEVER(a_count_bound, clock, reset, count_ff > POOL_C)
   `LLQM_ASSERT_NEXT(a_pop_decrements, clock, reset,
      cmd.commit && (cmd_ff == llqm_pkg::CMD_POP_FRONT) && (count_ff != '0),
      count_ff == $past(count_ff) - CW'(1))
   `LLQM_ASSERT_NEXT(a_idle_holds, clock, reset, !cmd.commit,
      $stable(count_ff) && $stable(head_ff) && $stable(tail_ff))

endmodule

`default_nettype wire

@@ hw/rtl/linked_list_queue_manager_unit.sv @@
// top level of the linked list queue manager
//
//  channel   dir  handshake      payload
//  req_chan  in   valid/ready    command[1:0], node_handle[7:0]
//  rsp_chan  out  valid/ready    front_handle, is_empty, entry_count,
//                                popped_handle, popped_valid
//
// each transaction has an accept step (link memory read at the head),
// then an execute step (list update and result register load)
// the link memory read for the successor of the head happens in the accept step
// a new command is accepted while the previous result waits in the output register
// a stalled result holds execution of the next command until it is taken
// reset clears head, tail, count and control; the link memory is not cleared
`timescale 1ns / 1ps
`default_nettype none

module linked_list_queue_manager_unit #(
   parameter int unsigned NODES = llqm_pkg::NODES_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   llqm_req_if.sink    req_chan,
   llqm_rsp_if.source  rsp_chan
);

   localparam int unsigned POOL =
      (NODES < llqm_pkg::MAX_POOL) ? NODES : llqm_pkg::MAX_POOL;

   llqm_pkg::ctrl_cmd_type cmd;

   llqm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   llqm_dp #(
      .POOL (POOL)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .command       (req_chan.command),
      .node_handle   (req_chan.node_handle),
      .front_handle  (rsp_chan.front_handle),
      .is_empty      (rsp_chan.is_empty),
      .entry_count   (rsp_chan.entry_count),
      .popped_handle (rsp_chan.popped_handle),
      .popped_valid  (rsp_chan.popped_valid)
   );

endmodule

`default_nettype wire

@@ sim/testbench.sv @@
// self-checking testbench for the linked list queue manager unit
`timescale 1ns / 1ps

module testbench;

   localparam int unsigned HW           = llqm_pkg::HANDLE_W;
   localparam int unsigned CW           = llqm_pkg::COUNT_W;
   localparam int unsigned POOL         = llqm_pkg::MAX_POOL;
   localparam int unsigned TOTAL_ITEMS  = 1700;
   localparam int unsigned QUIET_AFTER  = 1450;
   localparam int unsigned LONG_HOLD    = 200;
   localparam int unsigned STALL_LIMIT  = 5000;
   localparam int unsigned DRAIN_CYCLES = 20;

   typedef enum {GROW, SHRINK, MIXED} traffic_mode_type;

   typedef struct packed {
      logic [HW-1:0] front;
      logic          empty;
      logic [CW-1:0] count;
      logic [HW-1:0] popped;
      logic          popped_ok;
   } list_status_type;

   // mirrors the list state and holds the status each accepted command must produce
   class list_scoreboard;
      bit [HW-1:0]       head;
      bit [HW-1:0]       tail;
      bit [CW-1:0]       count;
      bit [HW-1:0]       link [POOL];
      bit                written [POOL];
      int unsigned       held [POOL];
      list_status_type   status_queue [$];
      int unsigned       errors;

      function void note_command(llqm_pkg::cmd_type cmd, logic [HW-1:0] h);
         list_status_type s;
         bit room;
         s = '0;
         room = (h < POOL) && (count < POOL);
         case (cmd)
            llqm_pkg::CMD_PUSH_BACK: if (room) begin
               if (count != 0) begin
                  link[tail] = h;
                  written[tail] = 1'b1;
               end else begin
                  head = h;
               end
               tail = h;
               count++;
               held[h]++;
            end
            llqm_pkg::CMD_PUSH_FRONT: if (room) begin
               if (count != 0) begin
                  link[h] = head;
                  written[h] = 1'b1;
               end else begin
                  tail = h;
               end
               head = h;
               count++;
               held[h]++;
            end
            llqm_pkg::CMD_POP_FRONT: if (count != 0) begin
               s.popped = head;
               s.popped_ok = 1'b1;
               if (held[head] != 0) held[head]--;
               count--;
               // last node out leaves head and tail where they were
               if (count != 0) head = link[head];
            end
            default: ;
         endcase
         s.empty = (count == 0);
         s.count = count;
         s.front = (count != 0) ? head : '0;
         status_queue.push_back(s);
      endfunction

      function void compare_field(string field, logic [CW-1:0] want,
                                  logic [CW-1:0] got);
         if (got !== want) begin
            $display("%0t mismatch %s: expected %0d, actual %0d", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_status(logic [HW-1:0] front, logic empty,
                                 logic [CW-1:0] cnt, logic [HW-1:0] popped,
                                 logic popped_ok);
         list_status_type want;
         if (status_queue.size() == 0) begin
            $display("%0t unexpected result: expected none, actual front %0d empty %0d",
                     $time, front, empty);
            $display("%0t   count %0d popped %0d valid %0d",
                     $time, cnt, popped, popped_ok);
            errors++;
            return;
         end
         want = status_queue.pop_front();
         // front handle carries no meaning on an empty list
         if (!want.empty) compare_field("front_handle", CW'(want.front), CW'(front));
         compare_field("is_empty", CW'(want.empty), CW'(empty));
         compare_field("entry_count", want.count, cnt);
         compare_field("popped_handle", CW'(want.popped), CW'(popped));
         compare_field("popped_valid", CW'(want.popped_ok), CW'(popped_ok));
      endfunction

      function int unsigned pending();
         return status_queue.size();
      endfunction
   endclass

   logic clock;
   logic reset;
   bit quiet;
   bit long_hold;
   int unsigned items_sent;
   int unsigned gap_pct;
   int unsigned stall_cycles = 0;
   list_scoreboard sb;

   llqm_req_if req_chan ();
   llqm_rsp_if rsp_chan ();

   linked_list_queue_manager_unit dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && req_chan.valid && req_chan.ready)
         sb.note_command(llqm_pkg::cmd_type'(req_chan.command), req_chan.node_handle);
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready)
         sb.check_status(rsp_chan.front_handle, rsp_chan.is_empty, rsp_chan.entry_count,
                         rsp_chan.popped_handle, rsp_chan.popped_valid);
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("[linked_list_queue_manager_unit] ERROR");
            $finish;
         end
      end
   end

   // result side back-pressure
   initial begin
      rsp_chan.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (long_hold) begin
            rsp_chan.ready = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
            long_hold = 1'b0;
         end else if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_chan.ready = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge clock);
         end else begin
            rsp_chan.ready = 1'b1;
            repeat (quiet ? 1 : $urandom_range(1, 16)) @(negedge clock);
         end
      end
   end

   // called at a falling edge, returns at the falling edge after the transaction
   task automatic issue(input llqm_pkg::cmd_type cmd, input logic [HW-1:0] h);
      req_chan.valid = 1'b1;
      req_chan.command = cmd;
      req_chan.node_handle = h;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      @(negedge clock);
      items_sent++;
      if (items_sent >= QUIET_AFTER) quiet = 1'b1;
      if (!quiet && $urandom_range(0, 99) < gap_pct) begin
         req_chan.valid = 1'b0;
         repeat ($urandom_range(1, 12)) @(negedge clock);
      end
   endtask

   function automatic logic [HW-1:0] pick_handle(bit want_held);
      int unsigned start;
      start = $urandom_range(0, POOL - 1);
      for (int unsigned i = 0; i < POOL; i++)
         if ((sb.held[(start + i) % POOL] != 0) == want_held) return HW'((start + i) % POOL);
      return HW'(start);
   endfunction

   // a pop must never follow a link that was never written
   function automatic bit pop_is_safe();
      return sb.count < 2 || sb.written[sb.head];
   endfunction

   task automatic pick_item(input traffic_mode_type mode, output llqm_pkg::cmd_type cmd,
                            output logic [HW-1:0] h);
      int unsigned r;
      int unsigned push_pct;
      int unsigned pop_pct;
      r = $urandom_range(0, 99);
      case (mode)
         GROW:    begin push_pct = 75; pop_pct = 15; end
         SHRINK:  begin push_pct = 15; pop_pct = 75; end
         default: begin push_pct = 40; pop_pct = 40; end
      endcase
      h = HW'($urandom_range(0, POOL - 1));
      if (r < push_pct) begin
         cmd = $urandom_range(0, 1) ? llqm_pkg::CMD_PUSH_FRONT : llqm_pkg::CMD_PUSH_BACK;
         // now and then push a node that is already linked
         h = pick_handle($urandom_range(0, 99) < 3);
      end else if (r < push_pct + pop_pct) begin
         cmd = pop_is_safe() ? llqm_pkg::CMD_POP_FRONT : llqm_pkg::CMD_QUERY;
      end else begin
         cmd = llqm_pkg::CMD_QUERY;
      end
   endtask

   initial begin
      llqm_pkg::cmd_type cmd;
      logic [HW-1:0] h;
      int unsigned episode;
      int unsigned span;
      traffic_mode_type mode;

      sb = new();
      reset = 1'b1;
      quiet = 1'b0;
      long_hold = 1'b0;
      items_sent = 0;
      gap_pct = 15;
      req_chan.valid = 1'b0;
      req_chan.command = llqm_pkg::CMD_QUERY;
      req_chan.node_handle = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty list, handle extremes, both push ends, last node out
      issue(llqm_pkg::CMD_QUERY, 8'h00);
      issue(llqm_pkg::CMD_POP_FRONT, 8'hff);
      issue(llqm_pkg::CMD_PUSH_BACK, 8'h00);
      issue(llqm_pkg::CMD_PUSH_BACK, 8'hff);
      issue(llqm_pkg::CMD_PUSH_FRONT, 8'h80);
      issue(llqm_pkg::CMD_PUSH_FRONT, 8'h7f);
      issue(llqm_pkg::CMD_QUERY, 8'haa);
      repeat (4) issue(llqm_pkg::CMD_POP_FRONT, 8'h55);
      issue(llqm_pkg::CMD_POP_FRONT, 8'h00);
      issue(llqm_pkg::CMD_PUSH_FRONT, 8'h55);
      issue(llqm_pkg::CMD_PUSH_BACK, 8'haa);
      issue(llqm_pkg::CMD_QUERY, 8'h33);
      issue(llqm_pkg::CMD_POP_FRONT, 8'hcc);
      issue(llqm_pkg::CMD_POP_FRONT, 8'h00);
      // node pushed twice links to itself
      issue(llqm_pkg::CMD_PUSH_BACK, 8'h09);
      issue(llqm_pkg::CMD_PUSH_FRONT, 8'h09);
      issue(llqm_pkg::CMD_POP_FRONT, 8'h00);
      issue(llqm_pkg::CMD_POP_FRONT, 8'h00);
      issue(llqm_pkg::CMD_QUERY, 8'h00);

      episode = 0;
      while (items_sent < TOTAL_ITEMS) begin
         gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 35);
         if (episode == 1) long_hold = 1'b1;
         if (episode == 6) begin
            req_chan.valid = 1'b0;
            while (sb.pending() != 0) @(negedge clock);
         end
         if (episode == 3 || episode == 11) begin
            // fill the whole pool, then push into a full list
            while (sb.count < POOL) begin
               cmd = $urandom_range(0, 1) ? llqm_pkg::CMD_PUSH_FRONT : llqm_pkg::CMD_PUSH_BACK;
               issue(cmd, pick_handle(1'b0));
            end
            issue(llqm_pkg::CMD_PUSH_BACK, HW'($urandom_range(0, POOL - 1)));
            issue(llqm_pkg::CMD_PUSH_FRONT, HW'($urandom_range(0, POOL - 1)));
         end else if (episode % 5 == 4) begin
            repeat (sb.count + 2) begin
               cmd = pop_is_safe() ? llqm_pkg::CMD_POP_FRONT : llqm_pkg::CMD_QUERY;
               issue(cmd, HW'($urandom_range(0, POOL - 1)));
            end
         end else begin
            span = $urandom_range(40, 120);
            mode = (episode == 1) ? GROW : traffic_mode_type'($urandom_range(0, 2));
            repeat (span) begin
               if (items_sent < TOTAL_ITEMS) begin
                  pick_item(mode, cmd, h);
                  issue(cmd, h);
               end
            end
         end
         episode++;
      end

      req_chan.valid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("[linked_list_queue_manager_unit] OK");
      else
         $display("[linked_list_queue_manager_unit] ERROR");
      $finish;
   end

endmodule
